// ===== hdl/pzn_pkg.sv =====
// Shared types and constants for the per-sample z-score normalizer.
// No dependencies; every module of the block imports this package.
package pzn_pkg;

  localparam int DEF_MAX_ELEMENTS = 4096;
  localparam int MATH_W = 64;
  localparam int DATA_W = 16;
  localparam int CFG_W = 16;
  localparam int ELEM_CNT_W = 13;

  typedef enum logic [1:0] {
    CFG_ELEMENT_COUNT  = 2'd0,
    CFG_USER_ENABLE    = 2'd1,
    CFG_USER_MEAN      = 2'd2,
    CFG_USER_DEVIATION = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_SQ,
    ST_MUL_MAG,
    ST_CHECK,
    ST_ROOT,
    ST_DIV_INV,
    ST_DIV_MEAN,
    ST_RD_MUL,
    ST_RD_ROUND,
    ST_RD_SCALE,
    ST_RD_DIV,
    ST_EMIT
  } pzn_state_t;

  typedef struct packed {
    logic              start;
    logic [MATH_W-1:0] dividend;
    logic [MATH_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [MATH_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic              start;
    logic [MATH_W-1:0] value;
  } root_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [MATH_W/2-1:0] root;
  } root_rsp_t;

endpackage

// ===== hdl/pzn_store.sv =====
// Sample element memory, one write port and one registered read port.
// Depends on pzn_pkg for the element width.
module pzn_store import pzn_pkg::*; #(
  parameter int DEPTH = DEF_MAX_ELEMENTS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/pzn_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on pzn_pkg for the request and response structs.
module pzn_div import pzn_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(MATH_W);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  count;
  logic [MATH_W-1:0] dvd;
  logic [MATH_W-1:0] rem;
  logic [MATH_W-1:0] dsr;
  logic [MATH_W:0]   trial;
  logic              ge;
  logic [MATH_W-1:0] rem_next;
  logic [MATH_W-1:0] dvd_next;
  logic [MATH_W:0]   trial_diff;

  always_comb begin
    trial = {rem, dvd[MATH_W-1]};
    ge = trial >= {1'b0, dsr};
    trial_diff = trial - {1'b0, dsr};
    rem_next = ge ? trial_diff[MATH_W-1:0] : trial[MATH_W-1:0];
    dvd_next = {dvd[MATH_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      count <= '0;
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= dvd_next;
      rem <= rem_next;
      count <= count + 1'b1;
      busy <= (count != CNT_W'(MATH_W - 1));
      done <= (count == CNT_W'(MATH_W - 1));
    end else begin
      done <= 1'b0;
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quotient = dvd;

endmodule

// ===== hdl/pzn_root.sv =====
// Integer square root of a 64-bit value, one result bit per cycle.
// Depends on pzn_pkg for the request and response structs.
module pzn_root import pzn_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  root_req_t req,
  output root_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [MATH_W-1:0] v;
  logic [MATH_W-1:0] r;
  logic [MATH_W-1:0] bitm;
  logic [MATH_W-1:0] rb;

  assign rb = r + bitm;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      v <= req.value;
      r <= '0;
      bitm <= MATH_W'(1) << (MATH_W - 2);
    end else if (busy) begin
      if (v >= rb) begin
        v <= v - rb;
        r <= (r >> 1) + bitm;
      end else begin
        r <= r >> 1;
      end
      bitm <= bitm >> 2;
      busy <= !bitm[0];
      done <= bitm[0];
    end else begin
      done <= 1'b0;
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.root = r[MATH_W/2-1:0];

endmodule

// ===== hdl/per_sample_zscore_normalizer.sv =====
// Top level of the per-sample z-score normalizer: control, statistics and readout.
// Depends on pzn_pkg, pzn_store, pzn_div and pzn_root.
//
//   channel   direction  fields (low bit up)
//   s_*       in         tdata: sample_value; tuser: command; tlast: last_element
//   m_*       out        tdata: normalized_value; tuser: zero_filled, status; tlast
//   cfg_*     in         cfg_index selects the register, cfg_data holds its value
//
// The final load of a matching sample starts a sequence of shift-add multiplies
// (count and sum width in steps), a 32-step root and two 64-step divisions in the
// shared divider; a variance below one skips the root and the inverse division.
// A read steps through multiply, round and scale, plus a division with user normalization on.
// Reset is synchronous; the element memory is not cleared. A stalled result waits in
// the output register while the next request is already taken.
module per_sample_zscore_normalizer import pzn_pkg::*; #(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // sample_value
  input  logic              s_tlast,
  input  logic              s_tuser,   // command
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,   // normalized_value
  output logic              m_tlast,
  output logic [1:0]        m_tuser,   // zero_filled, status
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int ADDR_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 2);
  localparam int SUM_W = DATA_W + CNT_W;
  localparam int SQ_W = 2 * DATA_W - 1 + CNT_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);
  localparam logic [CNT_W-1:0] OVER_CNT = CNT_W'(MAX_ELEMENTS + 1);
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  function automatic logic [15:0] sat16(input logic neg, input logic [MATH_W-1:0] q);
    logic [15:0] r;
    if (!neg) begin
      r = (q > MATH_W'(32767)) ? 16'h7FFF : q[15:0];
    end else begin
      r = (q >= MATH_W'(32768)) ? 16'h8000 : (~q[15:0] + 16'd1);
    end
    return r;
  endfunction

  pzn_state_t state, state_next;

  logic [ELEM_CNT_W-1:0]  element_count;
  logic                   user_norm_enable;
  logic signed [15:0]     user_norm_mean;
  logic [15:0]            user_norm_deviation;

  logic [CNT_W-1:0]       loaded_count;
  logic signed [SUM_W-1:0] running_sum;
  logic [SQ_W-1:0]        running_square_sum;
  logic [CNT_W-1:0]       f_n;
  logic signed [SUM_W-1:0] f_sum;
  logic signed [15:0]     sample_mean;
  logic [31:0]            inverse_deviation;
  logic [CNT_W-1:0]       readout_index;
  logic [CNT_W-1:0]       readout_length;
  logic                   results_ready;
  logic                   sample_zeroed;

  logic [MATH_W-1:0]      ma, mb, acc, p1, var_v, nn;
  logic signed [49:0]     prod;
  logic                   z_neg;
  logic [41:0]            z_mag;
  logic [15:0]            res_value;
  logic                   pend_last, pend_zero, pend_status;

  logic                   in_acc, is_load, is_read, store_ok;
  logic signed [15:0]     x;
  logic signed [31:0]     xx;
  logic signed [SUM_W-1:0] sum_new;
  logic [SQ_W-1:0]        sq_new;
  logic [CNT_W-1:0]       cnt_new, eff_cnt, idx_inc;
  logic [SUM_W-1:0]       sum_mag;
  logic [2*CNT_W-1:0]     nn_prod;
  logic [MATH_W-1:0]      mean_dividend;
  logic [DATA_W-1:0]      rdata;
  logic signed [15:0]     elem;
  logic signed [16:0]     diff;
  logic signed [32:0]     inv_s;
  logic [49:0]            prod_mag;
  logic [49:0]            prod_rnd;
  logic [MATH_W-1:0]      plain_q;
  logic signed [42:0]     z_s;
  logic signed [45:0]     num;
  logic [45:0]            num_mag;
  logic [15:0]            dev_eff;
  logic [MATH_W-1:0]      user_dividend;
  logic [MATH_W-1:0]      mul_sum;

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  root_req_t root_req;
  root_rsp_t root_rsp;

  assign s_tready = (state == ST_IDLE);
  assign in_acc = s_tvalid && s_tready;
  assign is_load = in_acc && !s_tuser;
  assign is_read = in_acc && s_tuser;

  always_comb begin
    x = signed'(s_tdata);
    xx = x * x;
    store_ok = loaded_count < MAX_CNT;
    sum_new = store_ok ? running_sum + SUM_W'(x) : running_sum;
    sq_new = store_ok ? running_square_sum + SQ_W'(unsigned'(xx[30:0])) : running_square_sum;
    cnt_new = store_ok ? loaded_count + 1'b1 : OVER_CNT;
    if (element_count == '0) begin
      eff_cnt = CNT_W'(1);
    end else if (32'(element_count) > 32'(MAX_ELEMENTS)) begin
      eff_cnt = MAX_CNT;
    end else begin
      eff_cnt = CNT_W'(element_count);
    end
    idx_inc = readout_index + 1'b1;
    sum_mag = f_sum[SUM_W-1] ? unsigned'(-f_sum) : unsigned'(f_sum);
    nn_prod = f_n * f_n;
    mean_dividend = MATH_W'(sum_mag) + MATH_W'(f_n >> 1);
    mul_sum = acc + ma;
    elem = sample_zeroed ? 16'sd0 : signed'(rdata);
    diff = 17'(elem) - 17'(sample_mean);
    inv_s = signed'({1'b0, inverse_deviation});
    prod_mag = prod[49] ? unsigned'(-prod) : unsigned'(prod);
    prod_rnd = prod_mag + 50'd128;
    plain_q = (MATH_W'(z_mag) + MATH_W'(32)) >> 6;
    z_s = z_neg ? -signed'({1'b0, z_mag}) : signed'({1'b0, z_mag});
    num = (46'(z_s) - (46'(user_norm_mean) <<< 8)) <<< 2;
    num_mag = num[45] ? unsigned'(-num) : unsigned'(num);
    dev_eff = (user_norm_deviation == 16'd0) ? 16'd256 : user_norm_deviation;
    user_dividend = MATH_W'(num_mag) + MATH_W'(dev_eff >> 1);
  end

  pzn_store #(.DEPTH(MAX_ELEMENTS)) u_store (
    .clk   (clk),
    .we    (is_load && store_ok),
    .waddr (loaded_count[ADDR_W-1:0]),
    .wdata (s_tdata),
    .re    (is_read && results_ready),
    .raddr (readout_index[ADDR_W-1:0]),
    .rdata (rdata)
  );

  pzn_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  pzn_root u_root (
    .clk (clk),
    .rst (rst),
    .req (root_req),
    .rsp (root_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_req = '0;
    root_req = '0;
    unique case (state)
      ST_IDLE: begin
        if (is_load && s_tlast && cnt_new == eff_cnt) begin
          state_next = ST_MUL_SQ;
        end else if (is_read) begin
          state_next = results_ready ? ST_RD_MUL : ST_EMIT;
        end
      end
      ST_MUL_SQ: begin
        if (mb == '0) begin
          state_next = ST_MUL_MAG;
        end
      end
      ST_MUL_MAG: begin
        if (mb == '0) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (var_v < nn) begin
          div_req.start = 1'b1;
          div_req.dividend = mean_dividend;
          div_req.divisor = MATH_W'(f_n);
          state_next = ST_DIV_MEAN;
        end else begin
          root_req.start = 1'b1;
          root_req.value = var_v;
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_rsp.done) begin
          div_req.start = 1'b1;
          div_req.dividend = MATH_W'(f_n) << 24;
          div_req.divisor = MATH_W'(root_rsp.root);
          state_next = ST_DIV_INV;
        end
      end
      ST_DIV_INV: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          div_req.dividend = mean_dividend;
          div_req.divisor = MATH_W'(f_n);
          state_next = ST_DIV_MEAN;
        end
      end
      ST_DIV_MEAN: begin
        if (div_rsp.done) begin
          state_next = ST_IDLE;
        end
      end
      ST_RD_MUL: state_next = ST_RD_ROUND;
      ST_RD_ROUND: state_next = ST_RD_SCALE;
      ST_RD_SCALE: begin
        if (user_norm_enable) begin
          div_req.start = 1'b1;
          div_req.dividend = user_dividend;
          div_req.divisor = MATH_W'(dev_eff);
          state_next = ST_RD_DIV;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_RD_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= ELEM_CNT_W'(4096);
      user_norm_enable <= 1'b0;
      user_norm_mean <= '0;
      user_norm_deviation <= 16'd256;
      loaded_count <= '0;
      running_sum <= '0;
      running_square_sum <= '0;
      sample_mean <= '0;
      inverse_deviation <= '0;
      readout_index <= '0;
      readout_length <= '0;
      results_ready <= 1'b0;
      sample_zeroed <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_ELEMENT_COUNT:  element_count <= cfg_data[ELEM_CNT_W-1:0];
          CFG_USER_ENABLE:    user_norm_enable <= cfg_data[0];
          CFG_USER_MEAN:      user_norm_mean <= signed'(cfg_data);
          CFG_USER_DEVIATION: user_norm_deviation <= cfg_data;
        endcase
      end

      if (state == ST_EMIT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tdata <= res_value;
        m_tlast <= pend_last;
        m_tuser <= {pend_status, pend_zero};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (is_load) begin
            readout_index <= '0;
            if (s_tlast) begin
              loaded_count <= '0;
              running_sum <= '0;
              running_square_sum <= '0;
              f_n <= cnt_new;
              f_sum <= sum_new;
              readout_length <= eff_cnt;
              ma <= MATH_W'(sq_new);
              mb <= MATH_W'(cnt_new);
              acc <= '0;
              if (cnt_new != eff_cnt) begin
                sample_zeroed <= 1'b1;
                sample_mean <= '0;
                inverse_deviation <= ONE_Q16;
                results_ready <= 1'b1;
              end else begin
                sample_zeroed <= 1'b0;
                results_ready <= 1'b0;
              end
            end else begin
              results_ready <= 1'b0;
              loaded_count <= cnt_new;
              running_sum <= sum_new;
              running_square_sum <= sq_new;
            end
          end else if (is_read) begin
            if (results_ready) begin
              pend_status <= 1'b0;
              pend_last <= (idx_inc == readout_length);
              pend_zero <= sample_zeroed;
              if (idx_inc >= readout_length) begin
                results_ready <= 1'b0;
                readout_index <= '0;
              end else begin
                readout_index <= idx_inc;
              end
            end else begin
              pend_status <= 1'b1;
              pend_last <= 1'b0;
              pend_zero <= 1'b0;
              res_value <= '0;
            end
          end
        end
        ST_MUL_SQ: begin
          if (mb != '0) begin
            if (mb[0]) begin
              acc <= mul_sum;
            end
            ma <= ma << 1;
            mb <= mb >> 1;
          end else begin
            p1 <= acc;
            ma <= MATH_W'(sum_mag);
            mb <= MATH_W'(sum_mag);
            acc <= '0;
          end
        end
        ST_MUL_MAG: begin
          if (mb != '0) begin
            if (mb[0]) begin
              acc <= mul_sum;
            end
            ma <= ma << 1;
            mb <= mb >> 1;
          end else begin
            var_v <= p1 - acc;
            nn <= MATH_W'(nn_prod);
          end
        end
        ST_CHECK: begin
          if (var_v < nn) begin
            inverse_deviation <= ONE_Q16;
          end
        end
        ST_ROOT: begin
        end
        ST_DIV_INV: begin
          if (div_rsp.done) begin
            inverse_deviation <= div_rsp.quotient[31:0];
          end
        end
        ST_DIV_MEAN: begin
          if (div_rsp.done) begin
            sample_mean <= f_sum[SUM_W-1] ? signed'(~div_rsp.quotient[15:0] + 16'd1)
                                          : signed'(div_rsp.quotient[15:0]);
            results_ready <= 1'b1;
          end
        end
        ST_RD_MUL: begin
          prod <= diff * inv_s;
        end
        ST_RD_ROUND: begin
          z_neg <= prod[49];
          z_mag <= prod_rnd[49:8];
        end
        ST_RD_SCALE: begin
          if (!user_norm_enable) begin
            res_value <= sat16(z_neg, plain_q);
          end
        end
        ST_RD_DIV: begin
          if (div_rsp.done) begin
            res_value <= sat16(num[45], div_rsp.quotient);
          end
        end
        ST_EMIT: begin
        end
        default: begin
        end
      endcase
    end
  end

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    results_ready |-> readout_index < readout_length)
    else $error("readout index beyond readout length");

  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !div_rsp.busy && !root_rsp.busy)
    else $error("request accepted while an arithmetic unit is busy");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (m_tdata == 16'd0) && !m_tlast && !m_tuser[0])
    else $error("status result carries nonzero fields");

endmodule
